FILE: hdl/periodic_grid_stencil_unit_top_defines.svh
// Assertion macros shared by the stencil unit RTL
`ifndef PERIODIC_GRID_STENCIL_UNIT_TOP_DEFINES_SVH
`define PERIODIC_GRID_STENCIL_UNIT_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PGSU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define PGSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PGSU_ASSERT_SAME(lbl, ante, cons, msg)
`define PGSU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: hdl/pgsu_pkg.sv
// Package: types, constants and stencil tap tables of the stencil unit
`default_nettype none
package pgsu_pkg;

  localparam int GRID_SIZE  = 64;
  localparam int IDX_W      = $clog2(GRID_SIZE);
  localparam int PER_POINT  = 4;
  localparam int ADDR_W     = 2 * IDX_W + $clog2(PER_POINT);
  localparam int DEPTH      = GRID_SIZE * GRID_SIZE * PER_POINT;
  localparam int CFG_W      = 31;
  localparam int FIFO_DEPTH = 2;
  localparam int ACC_W      = 38;
  localparam int GAIN_W     = 62;
  localparam int PROD_W     = ACC_W + GAIN_W;

  // register indexes
  localparam logic [1:0] IDX_INV_DX    = 2'd0;
  localparam logic [1:0] IDX_INV_DX_SQ = 2'd1;
  localparam logic [1:0] IDX_DISS_GAIN = 2'd2;

  // input function codes
  localparam logic [2:0] FN_WRITE  = 3'd0;
  localparam logic [2:0] FN_FIRST  = 3'd1;
  localparam logic [2:0] FN_LAP    = 3'd2;
  localparam logic [2:0] FN_SECOND = 3'd3;
  localparam logic [2:0] FN_UPWIND = 3'd4;
  localparam logic [2:0] FN_DISS   = 3'd5;

  typedef enum logic [3:0] {
    OP_NONE, OP_WRITE, OP_FIRST, OP_LAP, OP_PURE2, OP_MIXED,
    OP_UP_POS, OP_UP_NEG, OP_DISS
  } op_t;

  typedef enum logic [1:0] {G_DX, G_DXSQ, G_DISS, G_UPWIND} gsel_t;

  typedef enum logic [3:0] {
    B_IDLE, B_WRITE, B_TAPS, B_GAIN, B_MUL, B_ROUND, B_DIV, B_SAT, B_DONE
  } bstate_t;

  typedef struct packed {
    op_t               op;
    logic              err;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [1:0]        rank;
    logic [1:0]        comp;
    logic              dir;
    logic              flip;
    logic [5:0]        kshift;
    logic              div12;
    gsel_t             gsel;
    logic [31:0]       shift_mag;
    logic [31:0]       sample;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic [CFG_W-1:0] inv_dx;
    logic [CFG_W-1:0] inv_dx_sq;
    logic [CFG_W-1:0] diss_gain;
  } cfg_t;

  typedef struct packed {
    logic signed [2:0] dr;
    logic signed [2:0] dc;
    logic signed [5:0] coef;
  } tap_t;

  function automatic tap_t mk_tap(logic signed [2:0] dr, logic signed [2:0] dc,
                                  logic signed [5:0] coef);
    tap_t t;
    t.dr = dr;
    t.dc = dc;
    t.coef = coef;
    return t;
  endfunction

  // tap offset k along one axis
  function automatic tap_t along(logic dir, logic signed [2:0] k,
                                 logic signed [5:0] coef);
    tap_t t;
    t = dir ? mk_tap(3'sd0, k, coef) : mk_tap(k, 3'sd0, coef);
    return t;
  endfunction

  function automatic logic [3:0] tap_count(op_t op);
    logic [3:0] n;
    unique case (op)
      OP_FIRST:  n = 4'd2;
      OP_LAP:    n = 4'd5;
      OP_PURE2:  n = 4'd3;
      OP_MIXED:  n = 4'd4;
      OP_UP_POS: n = 4'd5;
      OP_UP_NEG: n = 4'd5;
      OP_DISS:   n = 4'd9;
      default:   n = 4'd0;
    endcase
    return n;
  endfunction

  // stencil tap j of an operation
  function automatic tap_t tap_of(op_t op, logic dir, logic [3:0] j);
    tap_t t;
    t = mk_tap(3'sd0, 3'sd0, 6'sd0);
    unique case (op)
      OP_FIRST: begin
        t = (j == 4'd0) ? along(dir, 3'sd1, 6'sd1) : along(dir, -3'sd1, -6'sd1);
      end
      OP_LAP: begin
        unique case (j)
          4'd0:    t = mk_tap(3'sd0, 3'sd0, -6'sd4);
          4'd1:    t = along(1'b0, 3'sd1, 6'sd1);
          4'd2:    t = along(1'b0, -3'sd1, 6'sd1);
          4'd3:    t = along(1'b1, 3'sd1, 6'sd1);
          default: t = along(1'b1, -3'sd1, 6'sd1);
        endcase
      end
      OP_PURE2: begin
        unique case (j)
          4'd0:    t = mk_tap(3'sd0, 3'sd0, -6'sd2);
          4'd1:    t = along(dir, 3'sd1, 6'sd1);
          default: t = along(dir, -3'sd1, 6'sd1);
        endcase
      end
      OP_MIXED: begin
        unique case (j)
          4'd0:    t = mk_tap(3'sd1, 3'sd1, 6'sd1);
          4'd1:    t = mk_tap(3'sd1, -3'sd1, -6'sd1);
          4'd2:    t = mk_tap(-3'sd1, 3'sd1, -6'sd1);
          default: t = mk_tap(-3'sd1, -3'sd1, 6'sd1);
        endcase
      end
      OP_UP_POS: begin
        unique case (j)
          4'd0:    t = along(dir, 3'sd3, 6'sd1);
          4'd1:    t = along(dir, 3'sd2, -6'sd6);
          4'd2:    t = along(dir, 3'sd1, 6'sd18);
          4'd3:    t = mk_tap(3'sd0, 3'sd0, -6'sd10);
          default: t = along(dir, -3'sd1, -6'sd3);
        endcase
      end
      OP_UP_NEG: begin
        unique case (j)
          4'd0:    t = along(dir, -3'sd3, -6'sd1);
          4'd1:    t = along(dir, -3'sd2, 6'sd6);
          4'd2:    t = along(dir, -3'sd1, -6'sd18);
          4'd3:    t = mk_tap(3'sd0, 3'sd0, 6'sd10);
          default: t = along(dir, 3'sd1, 6'sd3);
        endcase
      end
      OP_DISS: begin
        unique case (j)
          4'd0:    t = along(1'b0, 3'sd2, 6'sd1);
          4'd1:    t = along(1'b0, 3'sd1, -6'sd4);
          4'd2:    t = along(1'b0, -3'sd1, -6'sd4);
          4'd3:    t = along(1'b0, -3'sd2, 6'sd1);
          4'd4:    t = along(1'b1, 3'sd2, 6'sd1);
          4'd5:    t = along(1'b1, 3'sd1, -6'sd4);
          4'd6:    t = along(1'b1, -3'sd1, -6'sd4);
          4'd7:    t = along(1'b1, -3'sd2, 6'sd1);
          default: t = mk_tap(3'sd0, 3'sd0, 6'sd12);
        endcase
      end
      default: t = mk_tap(3'sd0, 3'sd0, 6'sd0);
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/pgsu_front.sv
// Front end: accepts input words and classifies them into commands
`default_nettype none
module pgsu_front
  import pgsu_pkg::*;
(
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [87:0] in_tdata,  // row, col, tensor_rank, component, dir_first,
                                      // dir_second, shift_value, sample_value, zero pad
  input  wire logic [2:0]  in_tuser,  // func
  input  wire fifo_stat_t  stat,
  output logic             push,
  output cmd_t             cmd
);

  logic [2:0]  func;
  logic [1:0]  rank;
  logic [1:0]  comp;
  logic        d1;
  logic        d2;
  logic [31:0] shift;
  logic        bad;

  assign func  = in_tuser;
  assign rank  = in_tdata[13:12];
  assign comp  = in_tdata[15:14];
  assign d1    = in_tdata[16];
  assign d2    = in_tdata[17];
  assign shift = in_tdata[49:18];

  assign in_tready = !stat.full;
  assign push      = in_tvalid && !stat.full;

  // component must lie below DIM^rank; rank three is invalid
  always_comb begin
    unique case (rank)
      2'd0:    bad = (comp != 2'd0);
      2'd1:    bad = comp[1];
      2'd2:    bad = 1'b0;
      default: bad = 1'b1;
    endcase
  end

  // classification
  always_comb begin
    cmd           = '0;
    cmd.op        = OP_NONE;
    cmd.gsel      = G_DX;
    cmd.row       = in_tdata[5:0];
    cmd.col       = in_tdata[11:6];
    cmd.rank      = rank;
    cmd.comp      = comp;
    cmd.dir       = d1;
    cmd.sample    = in_tdata[81:50];
    cmd.shift_mag = shift[31] ? (~shift + 32'd1) : shift;
    cmd.kshift    = 6'd16;
    if (func <= FN_DISS) begin
      if (bad) begin
        cmd.err = 1'b1;
      end else begin
        unique case (func)
          FN_WRITE: cmd.op = OP_WRITE;
          FN_FIRST: begin
            cmd.op     = OP_FIRST;
            cmd.kshift = 6'd17;
          end
          FN_LAP: begin
            cmd.op   = OP_LAP;
            cmd.gsel = G_DXSQ;
          end
          FN_SECOND: begin
            cmd.gsel = G_DXSQ;
            if (d1 == d2) begin
              cmd.op = OP_PURE2;
            end else begin
              cmd.op     = OP_MIXED;
              cmd.kshift = 6'd18;
            end
          end
          FN_UPWIND: begin
            cmd.gsel   = G_UPWIND;
            cmd.kshift = 6'd32;
            cmd.div12  = 1'b1;
            cmd.flip   = shift[31];
            // zero shift gives zero
            if (shift != 32'd0) begin
              cmd.op = shift[31] ? OP_UP_NEG : OP_UP_POS;
            end
          end
          default: begin
            cmd.op   = OP_DISS;
            cmd.gsel = G_DISS;
            cmd.flip = 1'b1;
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/pgsu_fifo.sv
// Command queue between front and back end
`default_nettype none
module pgsu_fifo
  import pgsu_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire cmd_t  din,
  input  wire logic  pop,
  output cmd_t       dout,
  output fifo_stat_t stat
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  cmd_t             ent_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == CNT_W'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign dout       = ent_r[rd_r];

  // pointer and count update
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= din;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/pgsu_back.sv
// Back end: grid memory, stencil sequencer, scaling and output register
`default_nettype none
module pgsu_back
  import pgsu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  input  wire fifo_stat_t  stat,
  output logic             pop,
  input  wire cfg_t        cfg,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // result
  output logic             out_tuser   // error
);

  bstate_t state_r, state_nxt;

  cmd_t                    cmd_r;
  logic [3:0]              j_r;
  logic                    pend_r;
  logic signed [5:0]       coef_r;
  logic [31:0]             rd_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0]        smag_r;
  logic                    neg_r;
  logic [GAIN_W-1:0]       g_r;
  logic [2:0]              mi_r;
  logic [63:0]             pp_r;
  logic [PROD_W-1:0]       p_r;
  logic                    hi_r;
  logic [35:0]             mag_r;
  logic [35:0]             u_r;
  logic [1:0]              rem_r;
  logic [3:0]              dj_r;
  logic [31:0]             res_r;
  logic                    out_valid_r;
  logic [31:0]             out_res_r;
  logic                    out_err_r;

  logic [31:0] mem [DEPTH];

  logic              mem_we;
  logic              mem_re;
  logic              out_load;
  logic              out_free;
  logic [3:0]        cnt;
  tap_t              tap;
  logic [IDX_W-1:0]  rr;
  logic [IDX_W-1:0]  cc;
  logic [ADDR_W-1:0] addr;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r;
  assign out_tuser  = out_err_r;

  // tap address with wraparound
  assign cnt = tap_count(cmd_r.op);
  assign tap = tap_of(cmd_r.op, cmd_r.dir, j_r);
  always_comb begin
    rr = cmd_r.row;
    cc = cmd_r.col;
    if (state_r == B_TAPS) begin
      rr = cmd_r.row + IDX_W'(tap.dr);
      cc = cmd_r.col + IDX_W'(tap.dc);
    end
    addr = (ADDR_W'({rr, cc}) << cmd_r.rank) | ADDR_W'(cmd_r.comp);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!stat.empty) begin
          if (cmd.op == OP_WRITE) begin
            state_nxt = B_WRITE;
          end else if (cmd.op == OP_NONE) begin
            state_nxt = B_DONE;
          end else begin
            state_nxt = B_TAPS;
          end
        end
      end
      B_WRITE: state_nxt = B_DONE;
      B_TAPS:  if (j_r == cnt && !pend_r) state_nxt = B_GAIN;
      B_GAIN:  state_nxt = B_MUL;
      B_MUL:   if (mi_r == 3'd4) state_nxt = B_ROUND;
      B_ROUND: state_nxt = cmd_r.div12 ? B_DIV : B_SAT;
      B_DIV:   if (dj_r == 4'd8) state_nxt = B_SAT;
      B_SAT:   state_nxt = B_DONE;
      B_DONE:  if (out_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop      = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      B_IDLE:  pop = !stat.empty;
      B_WRITE: mem_we = 1'b1;
      B_TAPS:  mem_re = (j_r != cnt);
      B_DONE:  out_load = out_free;
      default: pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= mem_re;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // grid memory, one port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= cmd_r.sample;
    end
    if (mem_re) begin
      rd_r <= mem[addr];
    end
  end

  // 4-bit step of the divide by three
  logic [1:0] drem;
  logic [3:0] dq;
  logic [2:0] dcur;
  always_comb begin
    drem = rem_r;
    dq   = '0;
    dcur = '0;
    for (int b = 0; b < 4; b++) begin
      dcur = {drem, u_r[35-b]};
      if (dcur >= 3'd3) begin
        dq[3-b] = 1'b1;
        drem    = 2'(dcur - 3'd3);
      end else begin
        drem    = dcur[1:0];
      end
    end
  end

  // rounding add and shift
  logic [PROD_W-1:0] half;
  logic [PROD_W-1:0] tsum;
  always_comb begin
    half = ((cmd_r.div12 ? PROD_W'(12) : PROD_W'(1)) << cmd_r.kshift) >> 1;
    tsum = (p_r + half) >> cmd_r.kshift;
  end

  // partial product operands
  logic [31:0] ma;
  logic [31:0] mb;
  assign ma = mi_r[1] ? 32'(smag_r[ACC_W-1:32]) : smag_r[31:0];
  assign mb = mi_r[0] ? 32'(g_r[GAIN_W-1:32]) : g_r[31:0];

  // saturation
  logic [31:0] limit;
  logic        sat;
  assign limit = neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign sat   = hi_r || (mag_r > 36'(limit));

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        cmd_r <= cmd;
        j_r   <= '0;
        acc_r <= '0;
        res_r <= '0;
        mi_r  <= '0;
        p_r   <= '0;
      end
      B_TAPS: begin
        if (mem_re) begin
          j_r    <= j_r + 4'd1;
          coef_r <= tap.coef;
        end
        if (pend_r) begin
          acc_r <= acc_r + ACC_W'(coef_r) * ACC_W'($signed(rd_r));
        end
      end
      B_GAIN: begin
        smag_r <= acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
        neg_r  <= acc_r[ACC_W-1] ^ cmd_r.flip;
        unique case (cmd_r.gsel)
          G_DX:     g_r <= GAIN_W'(cfg.inv_dx);
          G_DXSQ:   g_r <= GAIN_W'(cfg.inv_dx_sq);
          G_DISS:   g_r <= GAIN_W'(cfg.diss_gain);
          default:  g_r <= GAIN_W'(cmd_r.shift_mag * cfg.inv_dx);
        endcase
      end
      B_MUL: begin
        mi_r <= mi_r + 3'd1;
        if (mi_r != 3'd4) begin
          pp_r <= ma * mb;
        end
        unique case (mi_r)
          3'd1:         p_r <= p_r + PROD_W'(pp_r);
          3'd2, 3'd3:   p_r <= p_r + (PROD_W'(pp_r) << 32);
          3'd4:         p_r <= p_r + (PROD_W'(pp_r) << 64);
          default:      p_r <= p_r;
        endcase
      end
      B_ROUND: begin
        dj_r  <= '0;
        rem_r <= '0;
        if (cmd_r.div12) begin
          hi_r <= |tsum[PROD_W-1:35];
          u_r  <= 36'(tsum[34:2]);
        end else begin
          hi_r <= |tsum[PROD_W-1:32];
        end
        mag_r <= 36'(tsum[31:0]);
      end
      B_DIV: begin
        dj_r  <= dj_r + 4'd1;
        rem_r <= drem;
        u_r   <= {u_r[31:0], 4'b0000};
        mag_r <= {mag_r[31:0], dq};
      end
      B_SAT: begin
        res_r <= neg_r ? (~(sat ? limit : mag_r[31:0]) + 32'd1)
                       : (sat ? limit : mag_r[31:0]);
      end
      default: begin
        j_r <= j_r;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r <= res_r;
      out_err_r <= cmd_r.err;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/periodic_grid_stencil_unit_top.sv
// Sequence: writes store the sample; stencil queries read each tap from the grid memory, then take 5
// multiplier steps, and upwinding adds 9 divide steps; rejected words, unused codes and
// zero-shift upwinding go straight to the output register.
// Flow: the back end handles one word at a time, through the single grid memory port and the
// shared 32x32 multiplier; a two-entry queue buffers input.
// Reset: synchronous, active low; resets control and config registers; grid memory is
// undefined until written.
`default_nettype none
`include "periodic_grid_stencil_unit_top_defines.svh"
module periodic_grid_stencil_unit_top
  import pgsu_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [87:0]      in_tdata,  // row, col, tensor_rank, component, dir_first,
                                           // dir_second, shift_value, sample_value, pad
  input  wire logic [2:0]       in_tuser,  // func
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [31:0]           out_tdata, // result
  output logic                  out_tuser, // error
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  cfg_t       cfg_r;
  fifo_stat_t stat;
  cmd_t       f_cmd;
  cmd_t       q_cmd;
  logic       push;
  logic       pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inv_dx    <= CFG_W'(65536);
      cfg_r.inv_dx_sq <= CFG_W'(65536);
      cfg_r.diss_gain <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        IDX_INV_DX:    cfg_r.inv_dx    <= cfg_wdata;
        IDX_INV_DX_SQ: cfg_r.inv_dx_sq <= cfg_wdata;
        IDX_DISS_GAIN: cfg_r.diss_gain <= cfg_wdata;
        default:       cfg_r           <= cfg_r;
      endcase
    end
  end

  pgsu_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .stat      (stat),
    .push      (push),
    .cmd       (f_cmd)
  );

  pgsu_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (f_cmd),
    .pop   (pop),
    .dout  (q_cmd),
    .stat  (stat)
  );

  pgsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (q_cmd),
    .stat       (stat),
    .pop        (pop),
    .cfg        (cfg_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // checks
  `PGSU_ASSERT_SAME(a_no_push_full, push, !stat.full, "push into full queue")
  `PGSU_ASSERT_SAME(a_no_pop_empty, pop, !stat.empty, "pop from empty queue")
  `PGSU_ASSERT_NEXT(a_cfg_dx, cfg_we && cfg_index == IDX_INV_DX, cfg_r.inv_dx == $past(cfg_wdata), "inv_dx write lost")
  `PGSU_ASSERT_NEXT(a_cfg_diss, cfg_we && cfg_index == IDX_DISS_GAIN, cfg_r.diss_gain == $past(cfg_wdata), "gain write lost")

endmodule
`default_nettype wire
